// ===== sv/crcs_pkg.sv =====
// ----------------------------------------------------------------------------
// crcs_pkg
// shared types, codes and step tables of the catmull-rom curve sampler
// ----------------------------------------------------------------------------
`default_nettype none

package crcs_pkg;

    // configuration register indexes (byte address bit 2)
    localparam logic REG_SAMPLES = 1'b0;
    localparam logic REG_CLOSED  = 1'b1;

    localparam logic [4:0] SAMPLES_RESET = 5'd20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X0,
        ST_X1,
        ST_X2,
        ST_Y0,
        ST_Y1,
        ST_Y2,
        ST_PUT,
        ST_ECHO
    } crcs_state_t;

    typedef enum logic [1:0] {
        HS_FIRST,
        HS_MID,
        HS_LAST
    } crcs_hstep_t;

    typedef struct packed {
        logic        en;
        crcs_hstep_t step;
    } crcs_hctl_t;

    // floor(65536 / n)
    function automatic logic [16:0] crcs_step_q(input logic [4:0] n);
        logic [16:0] q;
        unique case (n)
            5'd1:    q = 17'd65536;
            5'd2:    q = 17'd32768;
            5'd3:    q = 17'd21845;
            5'd4:    q = 17'd16384;
            5'd5:    q = 17'd13107;
            5'd6:    q = 17'd10922;
            5'd7:    q = 17'd9362;
            5'd8:    q = 17'd8192;
            5'd9:    q = 17'd7281;
            5'd10:   q = 17'd6553;
            5'd11:   q = 17'd5957;
            5'd12:   q = 17'd5461;
            5'd13:   q = 17'd5041;
            5'd14:   q = 17'd4681;
            5'd15:   q = 17'd4369;
            5'd16:   q = 17'd4096;
            5'd17:   q = 17'd3855;
            5'd18:   q = 17'd3640;
            5'd19:   q = 17'd3449;
            5'd20:   q = 17'd3276;
            5'd21:   q = 17'd3120;
            default: q = 17'd0;
        endcase
        return q;
    endfunction

    // 65536 mod n
    function automatic logic [4:0] crcs_step_r(input logic [4:0] n);
        logic [4:0] r;
        unique case (n)
            5'd3, 5'd5, 5'd15, 5'd17: r = 5'd1;
            5'd7, 5'd14:              r = 5'd2;
            5'd13:                    r = 5'd3;
            5'd6, 5'd12:              r = 5'd4;
            5'd19:                    r = 5'd5;
            5'd10:                    r = 5'd6;
            5'd9:                     r = 5'd7;
            5'd11:                    r = 5'd9;
            5'd18, 5'd20, 5'd21:      r = 5'd16;
            default:                  r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crcs_horner.sv =====
// ----------------------------------------------------------------------------
// crcs_horner
// shared horner unit: one q16 multiply-add per cycle while ctrl.en is set, rounded sample output
// ----------------------------------------------------------------------------
`default_nettype none

module crcs_horner #(
    parameter int CW = 16
) (
    input  wire logic                     clk,
    input  wire crcs_pkg::crcs_hctl_t     ctrl,
    input  wire logic signed [CW-1:0]     p1,
    input  wire logic signed [CW-1:0]     p2,
    input  wire logic signed [CW-1:0]     p3,
    input  wire logic signed [CW-1:0]     p4,
    input  wire logic        [16:0]       t,
    output logic signed      [CW-1:0]     sample
);
    import crcs_pkg::*;

    localparam int CF = CW + 4;
    localparam int AW = CW + 21;
    localparam int PW = AW + 18;
    localparam int VW = AW - 16;

    logic signed [CF-1:0] e1, e2, e3, e4;
    logic signed [CF-1:0] c0, c1, c2, c3, cadd;
    logic signed [AW-1:0] acc_reg, acc_next, opnd;
    logic signed [PW-1:0] prod, rnd;
    logic signed [AW:0]   fin;
    logic signed [VW-1:0] v;

    localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] VMIN = VW'(-(64'sd1 <<< (CW - 1)));

    always_comb
    begin
        e1 = CF'(p1);
        e2 = CF'(p2);
        e3 = CF'(p3);
        e4 = CF'(p4);
        c0 = e2 <<< 1;
        c1 = e3 - e1;
        c2 = (e1 <<< 1) - (e2 <<< 2) - e2 + (e3 <<< 2) - e4;
        c3 = (e2 <<< 1) + e2 - (e3 <<< 1) - e3 + e4 - e1;
        unique case (ctrl.step)
            HS_FIRST: cadd = c2;
            HS_MID:   cadd = c1;
            default:  cadd = c0;
        endcase
        if (ctrl.step == HS_FIRST)
            opnd = {AW'(c3) <<< 16};
        else
            opnd = acc_reg;
        prod     = PW'(opnd) * $signed({1'b0, t});
        rnd      = prod + PW'(32768);
        acc_next = {AW'(cadd) <<< 16} + rnd[AW+15:16];
        fin      = AW'(acc_reg) + (AW+1)'(65536);
        v        = fin[AW:17];
        if (v > VMAX)
            sample = VMAX[CW-1:0];
        else if (v < VMIN)
            sample = VMIN[CW-1:0];
        else
            sample = v[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
            acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

// ===== sv/catmull_rom_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_sampler
// uniform catmull-rom curve sampler over a stream of control points
// each sample runs on the one shared horner multiplier (x then y)
// a point producing s samples holds off the input until its last sample is put out, s <= 63
// a first sample goes out through states x0, x1, x2, y0, y1, y2 and put; an echo point through echo
// reset clears the window, point count, sequencer and output valid at once
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_curve_sampler #(
    parameter int COORD_BITS  = 16,
    parameter int MAX_SAMPLES = 21
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    // point_x, point_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // curve_x, curve_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import crcs_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int PTW = 2 * COORD_BITS;
    localparam int DW  = ((2 * COORD_BITS + 7) / 8) * 8;

    crcs_state_t state_reg, state_next;
    logic [4:0] samples_reg, samples_next;
    logic closed_reg, closed_next;
    logic [PTW-1:0] win_reg [3];
    logic [PTW-1:0] win_next [3];
    logic [PTW-1:0] first_reg [3];
    logic [PTW-1:0] first_next [3];
    logic [PTW-1:0] seq_reg [7];
    logic [PTW-1:0] seq_next [7];
    logic [1:0] seen_reg, seen_next;
    logic [2:0] nseg_reg, nseg_next;
    logic echo_reg, echo_next;
    logic [PTW-1:0] pt_reg, pt_next;
    logic [4:0] nsamp_reg, nsamp_next;
    logic [4:0] k_reg, k_next;
    logic [16:0] t_reg, t_next;
    logic [4:0] r_reg, r_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [CW-1:0] resx_reg, resx_next;
    logic m_valid_reg, m_valid_next;
    logic [DW-1:0] m_data_reg, m_data_next;
    logic m_last_reg, m_last_next;

    crcs_hctl_t hctl;
    logic use_y;
    logic signed [CW-1:0] hp1, hp2, hp3, hp4, sample;
    logic [PTW-1:0] pin;
    logic [4:0] neff;
    logic [5:0] rsum;
    logic out_free, last_k, cap, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign prdata  = (paddr[2] == REG_CLOSED) ? {31'd0, closed_reg} : {27'd0, samples_reg};
    assign pin     = s_axis_tdata[PTW-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign last_k  = (k_reg == nsamp_reg - 5'd1);
    assign cap     = (cnt_reg == 6'd62);
    assign rsum    = {1'b0, r_reg} + {1'b0, crcs_step_r(nsamp_reg)};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        if (samples_reg == 5'd0)
            neff = 5'd1;
        else if (samples_reg > 5'(MAX_SAMPLES))
            neff = 5'(MAX_SAMPLES);
        else
            neff = samples_reg;
    end

    always_comb
    begin
        hp1 = use_y ? seq_reg[0][PTW-1:CW] : seq_reg[0][CW-1:0];
        hp2 = use_y ? seq_reg[1][PTW-1:CW] : seq_reg[1][CW-1:0];
        hp3 = use_y ? seq_reg[2][PTW-1:CW] : seq_reg[2][CW-1:0];
        hp4 = use_y ? seq_reg[3][PTW-1:CW] : seq_reg[3][CW-1:0];
    end

    crcs_horner #(
        .CW (CW)
    ) u_horner (
        .clk    (clk),
        .ctrl   (hctl),
        .p1     (hp1),
        .p2     (hp2),
        .p3     (hp3),
        .p4     (hp4),
        .t      (t_reg),
        .sample (sample)
    );

    always_comb
    begin
        state_next   = state_reg;
        samples_next = samples_reg;
        closed_next  = closed_reg;
        win_next     = win_reg;
        first_next   = first_reg;
        seq_next     = seq_reg;
        seen_next    = seen_reg;
        nseg_next    = nseg_reg;
        echo_next    = echo_reg;
        pt_next      = pt_reg;
        nsamp_next   = nsamp_reg;
        k_next       = k_reg;
        t_next       = t_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        resx_next    = resx_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        hctl.en      = 1'b0;
        hctl.step    = HS_FIRST;
        use_y        = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_SAMPLES)
                samples_next = pwdata[4:0];
            else
                closed_next = pwdata[0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    nsamp_next = neff;
                    k_next     = 5'd0;
                    t_next     = 17'd0;
                    r_next     = neff >> 1;
                    cnt_next   = 6'd0;
                    pt_next    = pin;
                    nseg_next  = 3'd0;
                    echo_next  = 1'b0;
                    for (int i = 0; i < 7; i++)
                        seq_next[i] = pin;
                    if (!closed_reg)
                    begin
                        echo_next = s_axis_tlast;
                        if (seen_reg == 2'd1)
                        begin
                            seq_next[0] = win_reg[2];
                            seq_next[1] = win_reg[2];
                            nseg_next   = s_axis_tlast ? 3'd1 : 3'd0;
                        end
                        else if (seen_reg != 2'd0)
                        begin
                            seq_next[0] = (seen_reg == 2'd2) ? win_reg[1] : win_reg[0];
                            seq_next[1] = win_reg[1];
                            seq_next[2] = win_reg[2];
                            nseg_next   = s_axis_tlast ? 3'd2 : 3'd1;
                        end
                    end
                    else
                    begin
                        if (seen_reg == 2'd1)
                        begin
                            seq_next[0] = win_reg[2];
                            seq_next[1] = win_reg[2];
                            nseg_next   = s_axis_tlast ? 3'd1 : 3'd0;
                        end
                        else if (seen_reg == 2'd2)
                        begin
                            seq_next[0] = win_reg[1];
                            seq_next[1] = win_reg[2];
                            seq_next[3] = first_reg[0];
                            seq_next[4] = first_reg[1];
                            nseg_next   = s_axis_tlast ? 3'd3 : 3'd0;
                        end
                        else if (seen_reg == 2'd3)
                        begin
                            seq_next[0] = win_reg[0];
                            seq_next[1] = win_reg[1];
                            seq_next[2] = win_reg[2];
                            seq_next[4] = first_reg[0];
                            seq_next[5] = first_reg[1];
                            seq_next[6] = first_reg[2];
                            nseg_next   = s_axis_tlast ? 3'd4 : 3'd1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            win_next[i]   = '0;
                            first_next[i] = '0;
                        end
                        seen_next = 2'd0;
                    end
                    else
                    begin
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        win_next[2] = pin;
                        if (seen_reg != 2'd3)
                        begin
                            first_next[seen_reg] = pin;
                            seen_next = seen_reg + 2'd1;
                        end
                    end
                    if (nseg_next != 3'd0)
                        state_next = ST_X0;
                    else if (echo_next)
                        state_next = ST_ECHO;
                end
            end
            ST_X0:
            begin
                hctl.en    = 1'b1;
                state_next = ST_X1;
            end
            ST_X1:
            begin
                hctl.en    = 1'b1;
                hctl.step  = HS_MID;
                state_next = ST_X2;
            end
            ST_X2:
            begin
                hctl.en    = 1'b1;
                hctl.step  = HS_LAST;
                state_next = ST_Y0;
            end
            ST_Y0:
            begin
                resx_next  = sample;
                use_y      = 1'b1;
                hctl.en    = 1'b1;
                state_next = ST_Y1;
            end
            ST_Y1:
            begin
                use_y      = 1'b1;
                hctl.en    = 1'b1;
                hctl.step  = HS_MID;
                state_next = ST_Y2;
            end
            ST_Y2:
            begin
                use_y      = 1'b1;
                hctl.en    = 1'b1;
                hctl.step  = HS_LAST;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = DW'({sample, resx_reg});
                    m_last_next  = cap || (last_k && nseg_reg == 3'd1 && !echo_reg);
                    cnt_next     = cnt_reg + 6'd1;
                    if (cap)
                        state_next = ST_IDLE;
                    else if (last_k)
                    begin
                        if (nseg_reg == 3'd1)
                            state_next = echo_reg ? ST_ECHO : ST_IDLE;
                        else
                        begin
                            for (int i = 0; i < 6; i++)
                                seq_next[i] = seq_reg[i+1];
                            nseg_next  = nseg_reg - 3'd1;
                            k_next     = 5'd0;
                            t_next     = 17'd0;
                            r_next     = nsamp_reg >> 1;
                            state_next = ST_X0;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 5'd1;
                        if (rsum >= {1'b0, nsamp_reg})
                        begin
                            r_next = 5'(rsum - {1'b0, nsamp_reg});
                            t_next = t_reg + crcs_step_q(nsamp_reg) + 17'd1;
                        end
                        else
                        begin
                            r_next = rsum[4:0];
                            t_next = t_reg + crcs_step_q(nsamp_reg);
                        end
                        state_next = ST_X0;
                    end
                end
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = DW'(pt_reg);
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            samples_reg <= SAMPLES_RESET;
            closed_reg  <= 1'b0;
            seen_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i]   <= '0;
                first_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            samples_reg <= samples_next;
            closed_reg  <= closed_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
            first_reg   <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        nseg_reg   <= nseg_next;
        echo_reg   <= echo_next;
        pt_reg     <= pt_next;
        nsamp_reg  <= nsamp_next;
        k_reg      <= k_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
        cnt_reg    <= cnt_next;
        resx_reg   <= resx_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (cnt_reg <= 6'd62))
        else $error("result count past cap");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT && out_free && m_last_next) |=> (state_reg == ST_IDLE))
        else $error("last sample did not end the request");

    a_nsamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |-> (nsamp_reg != 5'd0 && nsamp_reg <= 5'(MAX_SAMPLES)
            && k_reg < nsamp_reg))
        else $error("sample index out of range");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (state_reg == ST_IDLE || state_reg == ST_X0 || state_reg == ST_ECHO))
        else $error("bad state after request");
`endif

endmodule

`default_nettype wire
